>>> design/pdq_pkg.sv
// positional deque package: command and status codes, word types
// and the plan passed from the command decoder to the sequencer
// no dependencies
package pdq_pkg;

  // command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [2:0] CMD_INSERT_AT  = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_POP_REAR   = 3'd4;
  localparam logic [2:0] CMD_REMOVE_AT  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BADPOS    = 2'd3;

  // word returned when nothing is removed
  localparam logic [31:0] NONE_WORD = 32'hFFFF_FFFF;

  localparam int unsigned OCC_W = 5;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] removed_value;
    logic [1:0]         status;
    logic [OCC_W-1:0]   occupancy;
  } out_word_t;

  // what the sequencer has to do with an accepted word
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_REMOVE
  } act_e;

  typedef struct packed {
    act_e       act;
    logic [1:0] status;
  } plan_t;

endpackage

>>> design/pdq_mem.sv
// entry store of the positional deque: one write port, one read port
// with registered read data; depends on nothing
module pdq_mem #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(CAPACITY)-1:0] waddr_i,
  input  logic [31:0]                 wdata_i,
  input  logic [$clog2(CAPACITY)-1:0] raddr_i,
  output logic [31:0]                 rdata_o
);

  logic [31:0] mem_q [CAPACITY];
  logic [31:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/pdq_seq.sv
// shift sequencer of the positional deque: moves one entry per cycle
// through the entry store, keeps the held count and the result register
// depends on pdq_pkg
module pdq_seq #(
  parameter int CAPACITY = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  pdq_pkg::plan_t                   plan_i,
  input  logic [$clog2(CAPACITY)-1:0]      idx_i,
  input  logic [31:0]                      value_i,
  output logic                             busy_o,
  output logic [$clog2(CAPACITY+1)-1:0]    count_o,
  output logic                             done_o,
  output pdq_pkg::out_word_t               res_o,
  output logic                             mem_we_o,
  output logic [$clog2(CAPACITY)-1:0]      mem_waddr_o,
  output logic [31:0]                      mem_wdata_o,
  output logic [$clog2(CAPACITY)-1:0]      mem_raddr_o,
  input  logic [31:0]                      mem_rdata_i
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WR,
    S_INS_PUT,
    S_REM_RD,
    S_REM_GRAB,
    S_REM_WR
  } state_e;

  state_e             state_q, state_d;
  logic [IW-1:0]      ptr_q, ptr_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [31:0]        val_q, val_d;
  logic [31:0]        rem_q, rem_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               done_q, done_d;
  pdq_pkg::out_word_t res_q, res_d;

  logic [CW:0]        ptr_ext;
  logic [CW:0]        cnt_ext;

  assign ptr_ext = (CW+1)'(ptr_q);
  assign cnt_ext = (CW+1)'(cnt_q);

  // next state, store access and result
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    val_d       = val_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    done_d      = 1'b0;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = ptr_q;
    case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          idx_d = idx_i;
          val_d = value_i;
          case (plan_i.act)
            pdq_pkg::ACT_INSERT: begin
              // start from the rear; read the word that moves up first
              ptr_d       = IW'(cnt_q);
              mem_raddr_o = IW'(cnt_q) - IW'(1);
              if (IW'(cnt_q) == idx_i) begin
                state_d = S_INS_PUT;
              end else begin
                state_d = S_INS_WR;
              end
            end
            pdq_pkg::ACT_REMOVE: begin
              ptr_d   = idx_i;
              state_d = S_REM_RD;
            end
            default: begin
              // error or unused code: answer at once
              done_d = 1'b1;
              res_d  = '{removed_value: pdq_pkg::NONE_WORD,
                         status: plan_i.status,
                         occupancy: pdq_pkg::OCC_W'(cnt_q)};
            end
          endcase
        end
      end
      S_INS_WR: begin
        // move one word up, read the next one below
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q;
        mem_wdata_o = mem_rdata_i;
        ptr_d       = ptr_q - IW'(1);
        mem_raddr_o = ptr_q - IW'(2);
        if (ptr_q - IW'(1) == idx_q) begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = val_q;
        cnt_d       = cnt_q + CW'(1);
        done_d      = 1'b1;
        res_d       = '{removed_value: pdq_pkg::NONE_WORD,
                        status: pdq_pkg::ST_OK,
                        occupancy: pdq_pkg::OCC_W'(cnt_q + CW'(1))};
        state_d     = S_IDLE;
      end
      S_REM_RD: begin
        // read the word being removed
        mem_raddr_o = ptr_q;
        state_d     = S_REM_GRAB;
      end
      S_REM_GRAB: begin
        rem_d       = mem_rdata_i;
        mem_raddr_o = ptr_q + IW'(1);
        if (ptr_ext + (CW+1)'(1) < cnt_ext) begin
          state_d = S_REM_WR;
        end else begin
          cnt_d   = cnt_q - CW'(1);
          done_d  = 1'b1;
          res_d   = '{removed_value: mem_rdata_i,
                      status: pdq_pkg::ST_OK,
                      occupancy: pdq_pkg::OCC_W'(cnt_q - CW'(1))};
          state_d = S_IDLE;
        end
      end
      S_REM_WR: begin
        // move one word down, read the next one above
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q;
        mem_wdata_o = mem_rdata_i;
        ptr_d       = ptr_q + IW'(1);
        mem_raddr_o = ptr_q + IW'(2);
        if (ptr_ext + (CW+1)'(2) >= cnt_ext) begin
          cnt_d   = cnt_q - CW'(1);
          done_d  = 1'b1;
          res_d   = '{removed_value: rem_q,
                      status: pdq_pkg::ST_OK,
                      occupancy: pdq_pkg::OCC_W'(cnt_q - CW'(1))};
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      idx_q   <= '0;
      val_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      idx_q   <= idx_d;
      val_q   <= val_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  assign busy_o  = (state_q != S_IDLE);
  assign count_o = cnt_q;
  assign done_o  = done_q;
  assign res_o   = res_q;

endmodule

>>> design/positional_deque.sv
// positional deque top level: command decode and range checks, shift
// sequencer and entry store; depends on pdq_pkg, pdq_seq, pdq_mem
//
//   channel   signals              direction  handshake
//   command   start, busy, cmd_i   in         taken when start and not busy
//   result    done_o, res_o        out        one-cycle strobe, no stall
//
// an error, full, underflow or unused command answers in the cycle after it
// is taken. an insert at index k moves the words from k up, rear first,
// then writes the new word; a removal at k reads that word and moves the
// rest down: one word per cycle through the single read and write port.
// reset empties the deque at once, the store itself is not cleared.
// busy stays high until the result is loaded; results cannot be held off.
module positional_deque #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pdq_pkg::in_word_t  cmd_i,
  output logic               done_o,
  output pdq_pkg::out_word_t res_o
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

  logic                seq_busy;
  logic [CW-1:0]       count;
  logic                accept;
  pdq_pkg::plan_t      plan;
  logic [IW-1:0]       idx;
  logic                full;
  logic                empty;
  logic [CMPW-1:0]     pos_ext;
  logic [CMPW-1:0]     cnt_ext;

  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [31:0]         mem_wdata;
  logic [IW-1:0]       mem_raddr;
  logic [31:0]         mem_rdata;

  assign accept  = start & ~seq_busy;
  assign busy    = seq_busy;
  assign full    = (count == CW'(CAPACITY));
  assign empty   = (count == '0);
  assign pos_ext = CMPW'(cmd_i.position);
  assign cnt_ext = CMPW'(count);

  // command decode: full and empty checks come before position checks
  always_comb begin
    plan.act    = pdq_pkg::ACT_NONE;
    plan.status = pdq_pkg::ST_OK;
    idx         = '0;
    case (cmd_i.cmd)
      pdq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          plan.status = pdq_pkg::ST_FULL;
        end else begin
          plan.act = pdq_pkg::ACT_INSERT;
        end
      end
      pdq_pkg::CMD_PUSH_REAR: begin
        if (full) begin
          plan.status = pdq_pkg::ST_FULL;
        end else begin
          plan.act = pdq_pkg::ACT_INSERT;
          idx      = IW'(count);
        end
      end
      pdq_pkg::CMD_INSERT_AT: begin
        if (full) begin
          plan.status = pdq_pkg::ST_FULL;
        end else if (pos_ext == '0 || pos_ext > cnt_ext + CMPW'(1)) begin
          plan.status = pdq_pkg::ST_BADPOS;
        end else begin
          plan.act = pdq_pkg::ACT_INSERT;
          idx      = IW'(pos_ext - CMPW'(1));
        end
      end
      pdq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          plan.status = pdq_pkg::ST_UNDERFLOW;
        end else begin
          plan.act = pdq_pkg::ACT_REMOVE;
        end
      end
      pdq_pkg::CMD_POP_REAR: begin
        if (empty) begin
          plan.status = pdq_pkg::ST_UNDERFLOW;
        end else begin
          plan.act = pdq_pkg::ACT_REMOVE;
          idx      = IW'(cnt_ext - CMPW'(1));
        end
      end
      pdq_pkg::CMD_REMOVE_AT: begin
        if (empty) begin
          plan.status = pdq_pkg::ST_UNDERFLOW;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          plan.status = pdq_pkg::ST_BADPOS;
        end else begin
          plan.act = pdq_pkg::ACT_REMOVE;
          idx      = IW'(pos_ext - CMPW'(1));
        end
      end
      default: begin
        plan.act    = pdq_pkg::ACT_NONE;
        plan.status = pdq_pkg::ST_OK;
      end
    endcase
  end

  // shift sequencer
  pdq_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .plan_i      (plan),
    .idx_i       (idx),
    .value_i     (cmd_i.value),
    .busy_o      (seq_busy),
    .count_o     (count),
    .done_o      (done_o),
    .res_o       (res_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // entry store
  pdq_mem #(
    .CAPACITY (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

>>> bench/tb_top.sv
// self-checking bench for positional_deque: directed table, then random bursts
// checked against a shift-array predictor; depends on pdq_pkg and positional_deque
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH = 16;
  localparam int RAND_WORDS = 1430;
  localparam int REPORT_MAX = 10;

  // unused command codes, the block must ignore them
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_e;

  typedef struct {
    pdq_pkg::in_word_t  word;
    bit                 typed;
    pdq_pkg::out_word_t res;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  pdq_pkg::in_word_t  cmd_i;
  logic               done_o;
  pdq_pkg::out_word_t res_o;

  // shadow copy of the deque contents, front at index 0
  logic [31:0] deque_words [DEPTH];
  int          deque_count = 0;

  pdq_pkg::out_word_t expected_results[$];
  dir_row_t           dir_rows[$];
  int                 error_count = 0;
  bit                 idle_on;

  positional_deque #(.CAPACITY(DEPTH)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit, several times the slowest legal run
  initial begin
    #3000000;
    $display("positional_deque test failed");
    $finish;
  end

  // apply one command to the shadow deque and return its result word
  function automatic pdq_pkg::out_word_t apply_command(input pdq_pkg::in_word_t w);
    pdq_pkg::out_word_t r;
    int idx;
    int i;
    r.removed_value = pdq_pkg::NONE_WORD;
    r.status = pdq_pkg::ST_OK;
    idx = -1;
    case (w.cmd)
      pdq_pkg::CMD_PUSH_FRONT, pdq_pkg::CMD_PUSH_REAR, pdq_pkg::CMD_INSERT_AT: begin
        if (deque_count >= DEPTH) begin
          r.status = pdq_pkg::ST_FULL;
        end else begin
          if (w.cmd == pdq_pkg::CMD_PUSH_FRONT) idx = 0;
          else if (w.cmd == pdq_pkg::CMD_PUSH_REAR) idx = deque_count;
          else if (w.position != 0 && w.position <= deque_count + 1) idx = w.position - 1;
          if (idx < 0) begin
            r.status = pdq_pkg::ST_BADPOS;
          end else begin
            for (i = deque_count; i > idx; i--) deque_words[i] = deque_words[i-1];
            deque_words[idx] = w.value;
            deque_count++;
          end
        end
      end
      pdq_pkg::CMD_POP_FRONT, pdq_pkg::CMD_POP_REAR, pdq_pkg::CMD_REMOVE_AT: begin
        if (deque_count == 0) begin
          r.status = pdq_pkg::ST_UNDERFLOW;
        end else begin
          if (w.cmd == pdq_pkg::CMD_POP_FRONT) idx = 0;
          else if (w.cmd == pdq_pkg::CMD_POP_REAR) idx = deque_count - 1;
          else if (w.position != 0 && w.position <= deque_count) idx = w.position - 1;
          if (idx < 0) begin
            r.status = pdq_pkg::ST_BADPOS;
          end else begin
            r.removed_value = deque_words[idx];
            for (i = idx; i + 1 < deque_count; i++) deque_words[i] = deque_words[i+1];
            deque_count--;
          end
        end
      end
      default: ;
    endcase
    r.occupancy = deque_count[pdq_pkg::OCC_W-1:0];
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] c, input logic [4:0] p,
                                  input logic [31:0] v, input bit typed,
                                  input logic [1:0] st, input int occ);
    dir_row_t row;
    row.word.cmd = c;
    row.word.position = p;
    row.word.value = v;
    row.typed = typed;
    row.res.removed_value = pdq_pkg::NONE_WORD;
    row.res.status = st;
    row.res.occupancy = occ[pdq_pkg::OCC_W-1:0];
    dir_rows.push_back(row);
  endfunction

  // random command, biased toward growing or shrinking the deque
  function automatic pdq_pkg::in_word_t make_command(input mix_e mix);
    pdq_pkg::in_word_t w;
    int grow_pct;
    int r;
    int top;
    grow_pct = (mix == MIX_GROW) ? 75 : (mix == MIX_SHRINK) ? 25 : 50;
    r = $urandom_range(99);
    if (r < 3) begin
      w.cmd = r[0] ? CMD_SPARE_A : CMD_SPARE_B;
    end else if ($urandom_range(99) < grow_pct) begin
      case ($urandom_range(2))
        0:       w.cmd = pdq_pkg::CMD_PUSH_FRONT;
        1:       w.cmd = pdq_pkg::CMD_PUSH_REAR;
        default: w.cmd = pdq_pkg::CMD_INSERT_AT;
      endcase
    end else begin
      case ($urandom_range(2))
        0:       w.cmd = pdq_pkg::CMD_POP_FRONT;
        1:       w.cmd = pdq_pkg::CMD_POP_REAR;
        default: w.cmd = pdq_pkg::CMD_REMOVE_AT;
      endcase
    end
    // mostly legal positions, some anywhere in the field
    if (w.cmd == pdq_pkg::CMD_INSERT_AT) top = deque_count + 1;
    else top = (deque_count == 0) ? 1 : deque_count;
    if ($urandom_range(99) < 15) w.position = 5'($urandom_range(31));
    else w.position = 5'($urandom_range(top, 1));
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0:       w.value = 32'h8000_0000;
        1:       w.value = 32'h7FFF_FFFF;
        2:       w.value = 32'h0000_0000;
        default: w.value = 32'hFFFF_FFFF;
      endcase
    end else begin
      w.value = $urandom;
    end
    return w;
  endfunction

  // drive one word at the falling edge and hold it until taken
  task automatic send_word(input pdq_pkg::in_word_t w, input bit typed,
                           input pdq_pkg::out_word_t typed_res);
    pdq_pkg::out_word_t predicted;
    logic [63:0] noise;
    while (idle_on && $urandom_range(99) < 32) begin
      noise = {$urandom, $urandom};
      @(negedge clk_i);
      start <= 1'b0;
      cmd_i <= noise[39:0];
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= w;
    do @(posedge clk_i); while (busy);
    predicted = apply_command(w);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic report(input string msg);
    error_count++;
    if (error_count <= REPORT_MAX) $display("%s", msg);
  endtask

  // result checker, one strobe per command
  always @(posedge clk_i) begin
    pdq_pkg::out_word_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result word: value %h status %0d occ %0d",
                         res_o.removed_value, res_o.status, res_o.occupancy));
      end else begin
        want = expected_results.pop_front();
        if (res_o.removed_value !== want.removed_value || res_o.status !== want.status ||
            res_o.occupancy !== want.occupancy)
          report($sformatf("mismatch: want value %h status %0d occ %0d, got %h %0d %0d",
                           want.removed_value, want.status, want.occupancy,
                           res_o.removed_value, res_o.status, res_o.occupancy));
      end
    end
  end

  // stimulus
  initial begin
    mix_e              mix;
    int                burst_len;
    int                sent;
    int                burst_idx;
    int                k;
    pdq_pkg::in_word_t w;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    idle_on = 1'b1;

    // empty deque errors, bad positions, spare codes, extremes
    add_row(pdq_pkg::CMD_POP_FRONT,  5'd0,  32'd0,         1, pdq_pkg::ST_UNDERFLOW, 0);
    add_row(pdq_pkg::CMD_POP_REAR,   5'd31, 32'd0,         1, pdq_pkg::ST_UNDERFLOW, 0);
    add_row(pdq_pkg::CMD_REMOVE_AT,  5'd1,  32'd0,         1, pdq_pkg::ST_UNDERFLOW, 0);
    add_row(pdq_pkg::CMD_REMOVE_AT,  5'd0,  32'd0,         1, pdq_pkg::ST_UNDERFLOW, 0);
    add_row(pdq_pkg::CMD_INSERT_AT,  5'd0,  32'd5,         1, pdq_pkg::ST_BADPOS,    0);
    add_row(pdq_pkg::CMD_INSERT_AT,  5'd2,  32'd6,         1, pdq_pkg::ST_BADPOS,    0);
    add_row(CMD_SPARE_A,             5'd1,  32'h0000_1234, 1, pdq_pkg::ST_OK,        0);
    add_row(CMD_SPARE_B,             5'd31, 32'hFFFF_FFFF, 1, pdq_pkg::ST_OK,        0);
    add_row(pdq_pkg::CMD_PUSH_FRONT, 5'd0,  32'h7FFF_FFFF, 1, pdq_pkg::ST_OK,        1);
    add_row(pdq_pkg::CMD_PUSH_REAR,  5'd31, 32'h8000_0000, 1, pdq_pkg::ST_OK,        2);
    add_row(pdq_pkg::CMD_INSERT_AT,  5'd1,  32'h0000_0000, 0, pdq_pkg::ST_OK,        0);
    add_row(pdq_pkg::CMD_INSERT_AT,  5'd4,  32'hFFFF_FFFF, 0, pdq_pkg::ST_OK,        0);
    add_row(pdq_pkg::CMD_INSERT_AT,  5'd3,  32'h5555_5555, 0, pdq_pkg::ST_OK,        0);
    add_row(pdq_pkg::CMD_INSERT_AT,  5'd31, 32'hAAAA_AAAA, 1, pdq_pkg::ST_BADPOS,    5);
    add_row(pdq_pkg::CMD_REMOVE_AT,  5'd0,  32'd0,         1, pdq_pkg::ST_BADPOS,    5);
    add_row(pdq_pkg::CMD_REMOVE_AT,  5'd6,  32'd0,         1, pdq_pkg::ST_BADPOS,    5);
    add_row(pdq_pkg::CMD_REMOVE_AT,  5'd5,  32'd0,         0, pdq_pkg::ST_OK,        0);
    add_row(pdq_pkg::CMD_REMOVE_AT,  5'd1,  32'd0,         0, pdq_pkg::ST_OK,        0);
    add_row(pdq_pkg::CMD_REMOVE_AT,  5'd2,  32'd0,         0, pdq_pkg::ST_OK,        0);
    add_row(pdq_pkg::CMD_POP_REAR,   5'd0,  32'd0,         0, pdq_pkg::ST_OK,        0);
    add_row(pdq_pkg::CMD_POP_FRONT,  5'd0,  32'd0,         0, pdq_pkg::ST_OK,        0);
    add_row(pdq_pkg::CMD_POP_FRONT,  5'd0,  32'd0,         1, pdq_pkg::ST_UNDERFLOW, 0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);

    // random bursts, each leaning toward full, empty or neither
    sent = 0;
    burst_idx = 0;
    while (sent < RAND_WORDS) begin
      mix = mix_e'($urandom_range(2));
      burst_len = $urandom_range(60, 20);
      // now and then let the deque answer everything before going on
      if (burst_idx == 3 || $urandom_range(9) == 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk_i);
      end
      for (k = 0; k < burst_len && sent < RAND_WORDS; k++) begin
        idle_on = !(sent >= 500 && sent < 800);
        w = make_command(mix);
        send_word(w, 1'b0, '0);
        sent++;
      end
      burst_idx++;
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 4) @(posedge clk_i);

    if (error_count == 0 && expected_results.size() == 0)
      $display("positional_deque test passed");
    else
      $display("positional_deque test failed");
    $finish;
  end

endmodule
